FILE: sv/vtpg_pkg.sv
package vtpg_pkg;

  // Pipeline depth of the zone plate path, first coordinate stage excluded
  localparam int ZONE_LAT = 9;
  // Accept edge to result edge: input stage, zone path, output stage
  localparam int PIPE_LAT = ZONE_LAT + 2;

  // Video levels, 10-bit
  localparam logic [9:0] LEVEL_BLACK = 10'd64;
  localparam logic [9:0] LEVEL_WHITE = 10'd940;
  localparam logic [9:0] CHROMA_ZERO = 10'd512;

  typedef enum logic [2:0] {
    PAT_BLACK  = 3'd0,
    PAT_WHITE  = 3'd1,
    PAT_BORDER = 3'd2,
    PAT_LINEAR = 3'd3,
    PAT_SLANT  = 3'd4,
    PAT_ZONE   = 3'd5
  } pattern_e;

  typedef enum logic [2:0] {
    CFG_PATTERN      = 3'd0,
    CFG_FRAME_WIDTH  = 3'd1,
    CFG_FRAME_HEIGHT = 3'd2,
    CFG_PHASE_STEP   = 3'd3,
    CFG_GAIN         = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]  pattern;
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [31:0] zone_phase_step;
    logic [10:0] gain;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    pattern:         3'd0,
    frame_width:     13'd1920,
    frame_height:    13'd1080,
    zone_phase_step: 32'd0,
    gain:            11'd1024
  };

  typedef struct packed {
    logic [11:0] col;
    logic [11:0] row;
  } in_t;

  typedef struct packed {
    logic [9:0] luma;
    logic [9:0] chroma;
    logic       chroma_is_cr;
  } out_t;

  // Luma/chroma pair travelling between the pattern paths and the output
  typedef struct packed {
    logic [9:0] luma;
    logic [9:0] chroma;
  } pix_lvl_t;

endpackage

FILE: sv/vtpg_sine_rom.sv
module vtpg_sine_rom
  import vtpg_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic [$clog2(SINE_TABLE_DEPTH/4+1)-1:0]   addr,
  output logic [14:0]                               rd_data
);

  localparam int QUARTER = SINE_TABLE_DEPTH / 4;

  typedef logic [14:0] sine_tab_t [QUARTER+1];

  // First-quadrant Q15 sine from an odd Taylor series in Q30 radians
  function automatic logic [14:0] quarter_sine(input int unsigned k);
    logic [63:0]        t;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [14:0]        res;
    t    = (64'(k) * 64'd6746518852) / 64'(SINE_TABLE_DEPTH);
    term = t;
    sum  = signed'(t);
    term = (term * t) >> 30;
    term = (term * t) >> 30;
    term = term / 64'd6;
    sum  = sum - signed'(term);
    term = (term * t) >> 30;
    term = (term * t) >> 30;
    term = term / 64'd20;
    sum  = sum + signed'(term);
    term = (term * t) >> 30;
    term = (term * t) >> 30;
    term = term / 64'd42;
    sum  = sum - signed'(term);
    term = (term * t) >> 30;
    term = (term * t) >> 30;
    term = term / 64'd72;
    sum  = sum + signed'(term);
    term = (term * t) >> 30;
    term = (term * t) >> 30;
    term = term / 64'd110;
    sum  = sum - signed'(term);
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 64'sd16384) >>> 15;
    if (sum > 64'sd32767) begin
      res = 15'd32767;
    end else begin
      res = sum[14:0];
    end
    return res;
  endfunction

  function automatic sine_tab_t build_tab();
    sine_tab_t tab;
    for (int k = 0; k <= QUARTER; k++) begin
      tab[k] = quarter_sine(k);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_tab();

  // Registered table read
  always_ff @(posedge clk) begin
    rd_data <= SINE_TAB[addr];
  end

endmodule

FILE: sv/vtpg_zone.sv
module vtpg_zone
  import vtpg_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic [11:0] col,
  input  logic [11:0] row,
  input  cfg_t        cfg,
  output pix_lvl_t    lvl
);

  localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
  localparam int DW      = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SW      = 32 + DW;
  localparam int HALF    = SINE_TABLE_DEPTH / 2;
  localparam int QUARTER = SINE_TABLE_DEPTH / 4;
  localparam int QW      = $clog2(QUARTER + 1);

  // Rounded offsets: level * 2^25 + 2^24
  localparam logic signed [36:0] OFF_LUMA   = 37'sd502 * 37'sd33554432 + 37'sd16777216;
  localparam logic signed [36:0] OFF_CHROMA = 37'sd512 * 37'sd33554432 + 37'sd16777216;

  // Drop the Q25 fraction and clamp to 0..1023
  function automatic logic [9:0] zone_sat(input logic signed [36:0] v);
    logic [9:0] res;
    if (v < 0) begin
      res = 10'd0;
    end else if (v[35:25] > 11'd1023) begin
      res = 10'd1023;
    end else begin
      res = v[34:25];
    end
    return res;
  endfunction

  logic signed [13:0] dx_r, dy_r;
  logic signed [27:0] dx_sq, dy_sq;
  logic [25:0]        dx2_r, dy2_r;
  logic [26:0]        d_r;
  logic [31:0]        phase_nxt, phase_r;
  logic [SW-1:0]      scaled;
  logic [IDX_W-1:0]   idx, idx_fold;
  logic               neg_nxt;
  logic [QW-1:0]      qidx_nxt, qidx_r;
  logic               neg6_r, neg7_r, neg8_r, neg9_r;
  logic [14:0]        mag;
  logic [25:0]        mg_r;
  logic [34:0]        pl_r, pc_r;
  logic signed [36:0] vl, vc;
  pix_lvl_t           lvl_r;

  // Offsets from the frame centre, in half pixels
  always_ff @(posedge clk) begin
    dx_r <= $signed({1'b0, col, 1'b0}) - $signed({1'b0, cfg.frame_width});
    dy_r <= $signed({1'b0, row, 1'b0}) - $signed({1'b0, cfg.frame_height});
  end

  // Squares, each below 2^26
  assign dx_sq = dx_r * dx_r;
  assign dy_sq = dy_r * dy_r;

  always_ff @(posedge clk) begin
    dx2_r <= dx_sq[25:0];
    dy2_r <= dy_sq[25:0];
    d_r   <= {1'b0, dx2_r} + {1'b0, dy2_r};
  end

  // Phase in turns, modulo 2^32
  assign phase_nxt = {5'd0, d_r} * cfg.zone_phase_step;

  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;
  end

  // Table index and quadrant fold
  assign scaled   = {{DW{1'b0}}, phase_r} * SW'(SINE_TABLE_DEPTH);
  assign idx      = scaled[32 +: IDX_W];
  assign neg_nxt  = (idx >= IDX_W'(HALF));
  assign idx_fold = neg_nxt ? (idx - IDX_W'(HALF)) : idx;
  assign qidx_nxt = (idx_fold > IDX_W'(QUARTER)) ? QW'(IDX_W'(HALF) - idx_fold)
                                                 : QW'(idx_fold);

  always_ff @(posedge clk) begin
    qidx_r <= qidx_nxt;
    neg6_r <= neg_nxt;
  end

  vtpg_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_sine_rom (
    .clk     (clk),
    .addr    (qidx_r),
    .rd_data (mag)
  );

  // Amplitude scaling, sign kept aside
  always_ff @(posedge clk) begin
    neg7_r <= neg6_r;
    mg_r   <= {11'd0, mag} * {15'd0, cfg.gain};
    neg8_r <= neg7_r;
    pl_r   <= {9'd0, mg_r} * 35'd438;
    pc_r   <= {9'd0, mg_r} * 35'd448;
    neg9_r <= neg8_r;
  end

  // Offset, round and saturate
  assign vl = (neg9_r ? -$signed({2'b00, pl_r}) : $signed({2'b00, pl_r})) + OFF_LUMA;
  assign vc = (neg9_r ? -$signed({2'b00, pc_r}) : $signed({2'b00, pc_r})) + OFF_CHROMA;

  always_ff @(posedge clk) begin
    lvl_r.luma   <= zone_sat(vl);
    lvl_r.chroma <= zone_sat(vc);
  end

  assign lvl = lvl_r;

endmodule

FILE: sv/vtpg_ramp.sv
module vtpg_ramp
  import vtpg_pkg::*;
(
  input  logic        clk,
  input  logic [11:0] col,
  input  logic [11:0] row,
  input  cfg_t        cfg,
  output pix_lvl_t    lvl
);

  localparam logic [9:0] RAMP_SPAN      = 10'd877;
  localparam logic [9:0] SLANT_ROW_SPAN = 10'd876;
  localparam int         PAD            = ZONE_LAT - 2;

  // Remainder for values below six spans: parallel compares, one subtract
  function automatic logic [9:0] mod_span(input logic [12:0] v, input logic [9:0] span);
    logic [12:0] m;
    logic [12:0] r;
    m = 13'd0;
    r = v;
    for (int k = 1; k <= 5; k++) begin
      m = m + {3'd0, span};
      if (v >= m) begin
        r = v - m;
      end
    end
    return r[9:0];
  endfunction

  logic [9:0]  cm_a_r, rm_a_r;
  logic [11:0] col_a_r;
  logic        edge_a_r, edge_b_r;
  logic [9:0]  cm_b_r;
  logic [12:0] sum_b_r;
  logic [9:0]  slant;
  pix_lvl_t    lvl_nxt;
  pix_lvl_t    pad_r [PAD];

  // Stage A: remainders and border hit
  always_ff @(posedge clk) begin
    cm_a_r   <= mod_span({1'b0, col}, RAMP_SPAN);
    rm_a_r   <= mod_span({1'b0, row}, SLANT_ROW_SPAN);
    col_a_r  <= col;
    edge_a_r <= (row == 12'd0) || ({1'b0, row} == cfg.frame_height - 13'd1) ||
                (col == 12'd0) || ({1'b0, col} == cfg.frame_width - 13'd1);
  end

  // Stage B: slant sum
  always_ff @(posedge clk) begin
    sum_b_r  <= {3'd0, rm_a_r} + {1'b0, col_a_r};
    cm_b_r   <= cm_a_r;
    edge_b_r <= edge_a_r;
  end

  // Stage C: pattern select
  assign slant = mod_span(sum_b_r, RAMP_SPAN);

  always_comb begin
    lvl_nxt.luma   = LEVEL_BLACK;
    lvl_nxt.chroma = CHROMA_ZERO;
    unique case (pattern_e'(cfg.pattern))
      PAT_WHITE: begin
        lvl_nxt.luma = LEVEL_WHITE;
      end
      PAT_BORDER: begin
        lvl_nxt.luma = edge_b_r ? LEVEL_WHITE : LEVEL_BLACK;
      end
      PAT_LINEAR: begin
        lvl_nxt.luma   = LEVEL_BLACK + cm_b_r;
        lvl_nxt.chroma = LEVEL_BLACK + cm_b_r;
      end
      PAT_SLANT: begin
        lvl_nxt.luma   = LEVEL_BLACK + slant;
        lvl_nxt.chroma = LEVEL_BLACK + slant;
      end
      default: begin
        lvl_nxt.luma   = LEVEL_BLACK;
        lvl_nxt.chroma = CHROMA_ZERO;
      end
    endcase
  end

  // Delay line to line up with the zone plate path
  always_ff @(posedge clk) begin
    pad_r[0] <= lvl_nxt;
    for (int i = 1; i < PAD; i++) begin
      pad_r[i] <= pad_r[i-1];
    end
  end

  assign lvl = pad_r[PAD-1];

endmodule

FILE: sv/video_test_pattern_pixel_generator.sv
// Test pattern pixel generator, 10-bit 4:2:2 YCbCr. A coordinate beat is
// taken on every clock edge where start is high and busy is low; busy is
// high only during reset and up to the first edge after it, so one pixel per
// clock is sustained with no gaps. Each result appears on out_pix with
// out_valid high for a single cycle, in the order its coordinates were
// taken; the receiver cannot hold it off. The delay is set by the zone
// plate path: input register, centre offsets, squares, distance sum,
// phase multiply, table fold, sine table read, two gain multiplies and
// the rounding stage, followed by the output register.
// Configuration writes take effect at once and are meant to be made with
// the pipeline empty.
module video_test_pattern_pixel_generator
  import vtpg_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_t         in_pix,
  output logic        out_valid,
  output out_t        out_pix,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t                cfg_r;
  logic                busy_r;
  logic                v1_r;
  in_t                 pix1_r;
  logic [ZONE_LAT-1:0] vld_r;
  logic [ZONE_LAT-1:0] cr_r;
  pix_lvl_t            zone_lvl, ramp_lvl;
  logic                out_valid_r;
  out_t                out_pix_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_PATTERN:      cfg_r.pattern         <= cfg_data[2:0];
        CFG_FRAME_WIDTH:  cfg_r.frame_width     <= cfg_data[12:0];
        CFG_FRAME_HEIGHT: cfg_r.frame_height    <= cfg_data[12:0];
        CFG_PHASE_STEP:   cfg_r.zone_phase_step <= cfg_data;
        CFG_GAIN:         cfg_r.gain            <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Busy only through reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  // Input stage and valid / Cr flag line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      vld_r <= '0;
    end else begin
      v1_r  <= start && !busy_r;
      vld_r <= {vld_r[ZONE_LAT-2:0], v1_r};
    end
  end

  always_ff @(posedge clk) begin
    pix1_r <= in_pix;
    cr_r   <= {cr_r[ZONE_LAT-2:0], pix1_r.col[0]};
  end

  vtpg_zone #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_zone (
    .clk (clk),
    .col (pix1_r.col),
    .row (pix1_r.row),
    .cfg (cfg_r),
    .lvl (zone_lvl)
  );

  vtpg_ramp u_ramp (
    .clk (clk),
    .col (pix1_r.col),
    .row (pix1_r.row),
    .cfg (cfg_r),
    .lvl (ramp_lvl)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[ZONE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_r.pattern == PAT_ZONE) begin
      out_pix_r.luma   <= zone_lvl.luma;
      out_pix_r.chroma <= zone_lvl.chroma;
    end else begin
      out_pix_r.luma   <= ramp_lvl.luma;
      out_pix_r.chroma <= ramp_lvl.chroma;
    end
    out_pix_r.chroma_is_cr <= cr_r[ZONE_LAT-1];
  end

  assign out_valid = out_valid_r;
  assign out_pix   = out_pix_r;

endmodule

FILE: sv/vtpg_checker.sv
module vtpg_checker
  import vtpg_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input in_t         in_pix,
  input logic        out_valid,
  input out_t        out_pix
);

  // Every accepted beat gives a result after the fixed latency
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("accepted beat produced no result");

  // No result without a beat accepted that many cycles earlier
  a_lat_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result without matching accepted beat");

  // Cb/Cr flag follows the column parity of its beat
  a_cr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pix.chroma_is_cr == $past(in_pix.col[0], PIPE_LAT)))
    else $error("chroma_is_cr does not match column parity");

  // Reset holds off input and clears the result strobe
  a_rst: assert property (@(posedge clk)
    !rst_n |=> (busy && !out_valid))
    else $error("busy or out_valid wrong after reset");

endmodule

bind video_test_pattern_pixel_generator vtpg_checker u_vtpg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_pix    (in_pix),
  .out_valid (out_valid),
  .out_pix   (out_pix)
);
